>>> rtl/core/smsc_pkg.sv
`default_nettype none
package smsc_pkg;

  localparam int NUM_CH    = 6;
  localparam int SAMPLE_W  = 10;
  localparam int ANGLE_W   = 8;
  localparam int QUOT_W    = 9;  // quotient magnitude kept before saturation
  localparam int QCNT_W    = 4;
  localparam int CH_W      = 3;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [ANGLE_W-1:0]  angle_t;
  typedef sample_t [NUM_CH-1:0] sample_vec_t;
  typedef logic [CH_W-1:0]     ch_idx_t;

  localparam sample_t MID_SCALE = sample_t'(512);

  localparam logic [1:0] EMIT_NONE = 2'd3;

  // channels mapped on the y scale; channel five uses the grip range
  localparam logic [NUM_CH-1:0] Y_SCALE_MASK = 6'b110010;
  localparam ch_idx_t CH_GRIP = 3'd5;
  localparam ch_idx_t CH_LAST = 3'd5;

  localparam logic [2:0] REG_X_MIN    = 3'd0;
  localparam logic [2:0] REG_X_MAX    = 3'd1;
  localparam logic [2:0] REG_Y_MIN    = 3'd2;
  localparam logic [2:0] REG_Y_MAX    = 3'd3;
  localparam logic [2:0] REG_ARM_MIN  = 3'd4;
  localparam logic [2:0] REG_ARM_MAX  = 3'd5;
  localparam logic [2:0] REG_GRIP_MIN = 3'd6;
  localparam logic [2:0] REG_GRIP_MAX = 3'd7;

  typedef struct packed {
    logic [1:0] emitter;
    sample_t    x_sample;
    sample_t    y_sample;
  } in_item_t;

  typedef struct packed {
    angle_t base_angle;
    angle_t shoulder_angle;
    angle_t elbow_angle;
    angle_t wrist_tilt_angle;
    angle_t wrist_turn_angle;
    angle_t gripper_angle;
  } out_item_t;

  typedef struct packed {
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic    start;
    sample_t sample;
    sample_t in_lo;
    sample_t in_hi;
    angle_t  out_lo;
    angle_t  out_hi;
  } map_req_t;

  typedef struct packed {
    logic   done;
    angle_t angle;
  } map_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEDIAN,
    ST_MAP,
    ST_DONE
  } top_state_t;

  typedef enum logic [2:0] {
    MP_IDLE,
    MP_MUL,
    MP_PREP,
    MP_DIV,
    MP_FIN
  } map_state_t;

endpackage
`default_nettype wire

>>> rtl/core/smsc_cell.sv
`default_nettype none
// One window entry for all channels. Shifts toward the tail and ranks its
// samples against the candidate broadcast from the tail.
module smsc_cell (
  input  wire                      clk,
  input  wire                      rst,
  input  wire smsc_pkg::cell_ctrl_t  ctrl,
  input  wire smsc_pkg::sample_vec_t d_in,
  input  wire smsc_pkg::sample_vec_t cand,
  output smsc_pkg::sample_vec_t    d_out,
  output logic [smsc_pkg::NUM_CH-1:0] lt,
  output logic [smsc_pkg::NUM_CH-1:0] le
);
  import smsc_pkg::*;

  sample_vec_t q;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        q[c] <= MID_SCALE;
      end
    end else if (ctrl.shift) begin
      q <= d_in;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      lt[c] = q[c] < cand[c];
      le[c] = q[c] <= cand[c];
    end
  end

  assign d_out = q;

endmodule
`default_nettype wire

>>> rtl/core/smsc_mapper.sv
`default_nettype none
// Linear map of one sample onto an angle range with saturation.
// Multiply, then restoring division one quotient bit per cycle.
module smsc_mapper (
  input  wire                  clk,
  input  wire                  rst,
  input  wire smsc_pkg::map_req_t req,
  output smsc_pkg::map_rsp_t   rsp
);
  import smsc_pkg::*;

  map_state_t state, state_next;

  logic signed [SAMPLE_W:0]      diff;
  logic signed [ANGLE_W:0]       span;
  logic signed [SAMPLE_W:0]      den;
  logic signed [SAMPLE_W+ANGLE_W+1:0] prod;
  angle_t                        olo, lo, hi;
  logic                          neg, zero, ovf;
  logic [17:0]                   rem, dsh;
  logic [QUOT_W-1:0]             quot;
  logic [QCNT_W-1:0]             cnt;

  logic [SAMPLE_W+ANGLE_W+1:0]   pmag;
  logic [SAMPLE_W:0]             dmag_full;
  logic [SAMPLE_W-1:0]           dmag;
  logic [QUOT_W-1:0]             qmag;
  logic signed [ANGLE_W+2:0]     r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      MP_IDLE: if (req.start) state_next = MP_MUL;
      MP_MUL:  state_next = MP_PREP;
      MP_PREP: state_next = MP_DIV;
      MP_DIV:  if (cnt == QCNT_W'(QUOT_W - 1)) state_next = MP_FIN;
      MP_FIN:  state_next = MP_IDLE;
      default: state_next = MP_IDLE;
    endcase
  end

  always_comb begin
    pmag      = prod[SAMPLE_W+ANGLE_W+1] ? (-prod) : prod;
    dmag_full = den[SAMPLE_W] ? (-den) : den;
    dmag      = dmag_full[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    unique case (state)
      MP_IDLE: begin
        diff <= $signed({1'b0, req.sample}) - $signed({1'b0, req.in_lo});
        den  <= $signed({1'b0, req.in_hi}) - $signed({1'b0, req.in_lo});
        span <= $signed({1'b0, req.out_hi}) - $signed({1'b0, req.out_lo});
        olo  <= req.out_lo;
        lo   <= (req.out_lo < req.out_hi) ? req.out_lo : req.out_hi;
        hi   <= (req.out_lo < req.out_hi) ? req.out_hi : req.out_lo;
      end
      MP_MUL: begin
        prod <= diff * span;
      end
      MP_PREP: begin
        neg  <= prod[SAMPLE_W+ANGLE_W+1] ^ den[SAMPLE_W];
        zero <= (den == '0);
        ovf  <= pmag >= {1'b0, dmag, 9'b0};
        rem  <= pmag[17:0];
        dsh  <= {dmag, 8'b0};
        quot <= '0;
        cnt  <= '0;
      end
      MP_DIV: begin
        if (rem >= dsh) begin
          rem  <= rem - dsh;
          quot <= {quot[QUOT_W-2:0], 1'b1};
        end else begin
          quot <= {quot[QUOT_W-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt + QCNT_W'(1);
      end
      MP_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // any quotient of 512 or more lands outside the range, so 511 stands in
  always_comb begin
    qmag = ovf ? '1 : quot;
    if (neg) begin
      r = $signed({3'b0, olo}) - $signed({2'b0, qmag});
    end else begin
      r = $signed({3'b0, olo}) + $signed({2'b0, qmag});
    end
    rsp.done = (state == MP_FIN);
    if (zero) begin
      rsp.angle = olo;
    end else if (r < $signed({3'b0, lo})) begin
      rsp.angle = lo;
    end else if (r > $signed({3'b0, hi})) begin
      rsp.angle = hi;
    end else begin
      rsp.angle = r[ANGLE_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/six_channel_median_scale.sv
`default_nettype none
// Six-channel median filter with linear angle map.
// in channel: one joystick report per item (emitter, x_sample, y_sample).
//   Emitters 0..2 replace their channel pair; emitter 3 changes nothing but
//   the windows still advance. Every item gives exactly one out item.
// out channel: six angles, each the median of its channel's window mapped
//   from the joystick scale onto the arm or grip range and saturated.
// cfg channel: eight scale/range registers, always ready; write only while idle.
// Sequence: the windows rotate once through the cell row, then each channel in
//   turn passes the shared mapper (launch, multiply, prep, 9 divide steps,
//   finish), then the done state loads the output register.
// A new item is accepted only in the idle state, after the last item has
//   passed all these steps.
// A new item is taken while an earlier result still waits in the output
// register; if the receiver stalls longer, the finished result waits in the
// done state and no new item is taken.
// Reset: held samples zero, every window entry 512, registers to full scale.
module six_channel_median_scale #(
  parameter int WINDOW_DEPTH = 5
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire smsc_pkg::in_item_t in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output smsc_pkg::out_item_t   out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [2:0]             cfg_index,
  input  wire [9:0]             cfg_data
);
  import smsc_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [CNT_W-1:0] MED_IDX = CNT_W'(WINDOW_DEPTH / 2);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WINDOW_DEPTH - 1);

  top_state_t state, state_next;

  sample_t x_min, x_max, y_min, y_max;
  angle_t  arm_min, arm_max, grip_min, grip_max;

  sample_vec_t held, held_next;
  sample_t     med [NUM_CH];
  angle_t      res [NUM_CH];
  ch_idx_t     ch;
  logic [CNT_W-1:0] step;
  logic        map_busy;

  logic        in_acc;
  cell_ctrl_t  cctrl;
  sample_vec_t head_in, cand;
  sample_vec_t chain [WINDOW_DEPTH];
  logic [NUM_CH-1:0] lt_bits [WINDOW_DEPTH];
  logic [NUM_CH-1:0] le_bits [WINDOW_DEPTH];
  logic [CNT_W-1:0]  lt_cnt [NUM_CH];
  logic [CNT_W-1:0]  le_cnt [NUM_CH];

  map_req_t mreq;
  map_rsp_t mrsp;
  logic     use_y, use_grip;

  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min    <= '0;
      x_max    <= sample_t'(1023);
      y_min    <= '0;
      y_max    <= sample_t'(1023);
      arm_min  <= '0;
      arm_max  <= angle_t'(180);
      grip_min <= '0;
      grip_max <= angle_t'(180);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_X_MIN:    x_min    <= cfg_data;
        REG_X_MAX:    x_max    <= cfg_data;
        REG_Y_MIN:    y_min    <= cfg_data;
        REG_Y_MAX:    y_max    <= cfg_data;
        REG_ARM_MIN:  arm_min  <= cfg_data[ANGLE_W-1:0];
        REG_ARM_MAX:  arm_max  <= cfg_data[ANGLE_W-1:0];
        REG_GRIP_MIN: grip_min <= cfg_data[ANGLE_W-1:0];
        REG_GRIP_MAX: grip_max <= cfg_data[ANGLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    held_next = held;
    if (in_data.emitter != EMIT_NONE) begin
      held_next[{in_data.emitter, 1'b0}] = in_data.x_sample;
      held_next[{in_data.emitter, 1'b1}] = in_data.y_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (in_acc) begin
      held <= held_next;
    end
  end

  // Cell row: on accept the new samples enter at the head and the oldest
  // drop off the tail; during the median pass the row rotates once fully.
  assign cctrl.shift = in_acc || (state == ST_MEDIAN);
  assign cand        = chain[WINDOW_DEPTH-1];
  assign head_in     = (state == ST_IDLE) ? held_next : cand;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    smsc_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (cctrl),
      .d_in  ((i == 0) ? head_in : chain[(i == 0) ? 0 : i - 1]),
      .cand  (cand),
      .d_out (chain[i]),
      .lt    (lt_bits[i]),
      .le    (le_bits[i])
    );
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      lt_cnt[c] = '0;
      le_cnt[c] = '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        lt_cnt[c] = lt_cnt[c] + CNT_W'(lt_bits[i][c]);
        le_cnt[c] = le_cnt[c] + CNT_W'(le_bits[i][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_acc) state_next = ST_MEDIAN;
      ST_MEDIAN: if (step == LAST_STEP) state_next = ST_MAP;
      ST_MAP:    if (mrsp.done && ch == CH_LAST) state_next = ST_DONE;
      ST_DONE:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      ch       <= '0;
      map_busy <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          step     <= '0;
          ch       <= '0;
          map_busy <= 1'b0;
        end
        ST_MEDIAN: begin
          step <= step + CNT_W'(1);
        end
        ST_MAP: begin
          if (mrsp.done) begin
            map_busy <= 1'b0;
            ch       <= ch + CH_W'(1);
          end else if (mreq.start) begin
            map_busy <= 1'b1;
          end
        end
        ST_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // candidate at the tail is the median when its rank brackets the middle
  always_ff @(posedge clk) begin
    if (state == ST_MEDIAN) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (lt_cnt[c] <= MED_IDX && le_cnt[c] > MED_IDX) begin
          med[c] <= cand[c];
        end
      end
    end
    if (state == ST_MAP && mrsp.done) begin
      res[ch] <= mrsp.angle;
    end
  end

  always_comb begin
    use_y       = Y_SCALE_MASK[ch];
    use_grip    = (ch == CH_GRIP);
    mreq.start  = (state == ST_MAP) && !map_busy;
    mreq.sample = med[ch];
    mreq.in_lo  = use_y ? y_min : x_min;
    mreq.in_hi  = use_y ? y_max : x_max;
    mreq.out_lo = use_grip ? grip_min : arm_min;
    mreq.out_hi = use_grip ? grip_max : arm_max;
  end

  smsc_mapper u_mapper (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_data.base_angle       <= res[0];
      out_data.shoulder_angle   <= res[1];
      out_data.elbow_angle      <= res[2];
      out_data.wrist_tilt_angle <= res[3];
      out_data.wrist_turn_angle <= res[4];
      out_data.gripper_angle    <= res[5];
    end
  end

endmodule
`default_nettype wire

>>> test/smsc_checker.sv
`default_nettype none
module smsc_checker #(
  parameter int WINDOW_DEPTH = 5
) (
  input  wire       clk,
  input  wire       rst,
  input  wire       in_valid,
  input  wire       in_ready,
  input  wire smsc_pkg::in_item_t  in_data,
  input  wire       out_valid,
  input  wire       out_ready,
  input  wire smsc_pkg::out_item_t out_data,
  input  wire       cfg_valid,
  input  wire       cfg_ready,
  input  wire [2:0] cfg_index,
  input  wire [9:0] cfg_data,
  output int        fail_count,
  output int        pending,
  output int        checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import smsc_pkg::*;

  sample_t     held [NUM_CH];
  sample_t     windows [NUM_CH][WINDOW_DEPTH];
  int unsigned wr_pos;

  sample_t x_lo, x_hi, y_lo, y_hi;
  angle_t  arm_lo, arm_hi, grip_lo, grip_hi;

  out_item_t pending_angles [$];
  int        n_fail = 0;
  int        n_checked = 0;

  function automatic sample_t window_median(int ch);
    sample_t sorted [WINDOW_DEPTH];
    sample_t v;
    int      j;
    for (int i = 0; i < WINDOW_DEPTH; i++) sorted[i] = windows[ch][i];
    for (int i = 1; i < WINDOW_DEPTH; i++) begin
      v = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > v) begin
        sorted[j + 1] = sorted[j];
        j--;
      end
      sorted[j + 1] = v;
    end
    return sorted[WINDOW_DEPTH / 2];
  endfunction

  // signed math, quotient truncated toward zero, then clamped to the range
  function automatic angle_t scale_to_angle(sample_t v, sample_t in_lo, sample_t in_hi,
                                            angle_t out_lo, angle_t out_hi);
    longint den, r, lo, hi;
    den = longint'(in_hi) - longint'(in_lo);
    if (den == 0) return out_lo;
    lo = (out_lo < out_hi) ? longint'(out_lo) : longint'(out_hi);
    hi = (out_lo < out_hi) ? longint'(out_hi) : longint'(out_lo);
    r = (longint'(v) - longint'(in_lo)) * (longint'(out_hi) - longint'(out_lo)) / den
        + longint'(out_lo);
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return angle_t'(r);
  endfunction

  function automatic out_item_t predict_angles(in_item_t rpt);
    sample_t   med [NUM_CH];
    out_item_t a;
    if (rpt.emitter != EMIT_NONE) begin
      held[2 * rpt.emitter]     = rpt.x_sample;
      held[2 * rpt.emitter + 1] = rpt.y_sample;
    end
    wr_pos = (wr_pos + 1) % WINDOW_DEPTH;
    for (int c = 0; c < NUM_CH; c++) begin
      windows[c][wr_pos] = held[c];
      med[c] = window_median(c);
    end
    a.base_angle       = scale_to_angle(med[0], x_lo, x_hi, arm_lo, arm_hi);
    a.shoulder_angle   = scale_to_angle(med[1], y_lo, y_hi, arm_lo, arm_hi);
    a.elbow_angle      = scale_to_angle(med[2], x_lo, x_hi, arm_lo, arm_hi);
    a.wrist_tilt_angle = scale_to_angle(med[3], x_lo, x_hi, arm_lo, arm_hi);
    a.wrist_turn_angle = scale_to_angle(med[4], y_lo, y_hi, arm_lo, arm_hi);
    a.gripper_angle    = scale_to_angle(med[5], y_lo, y_hi, grip_lo, grip_hi);
    return a;
  endfunction

  function automatic void check_angle(string name, angle_t want, angle_t got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      foreach (held[c]) held[c] = '0;
      foreach (windows[c, k]) windows[c][k] = MID_SCALE;
      wr_pos  = 0;
      x_lo    = '0;
      x_hi    = 10'd1023;
      y_lo    = '0;
      y_hi    = 10'd1023;
      arm_lo  = '0;
      arm_hi  = 8'd180;
      grip_lo = '0;
      grip_hi = 8'd180;
      pending_angles.delete();
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (pending_angles.size() == 0) begin
          $display("%0t ns: unexpected angle set, expected none, got %h", $time, out_data);
          n_fail++;
        end else begin
          want = pending_angles.pop_front();
          check_angle("base_angle", want.base_angle, out_data.base_angle);
          check_angle("shoulder_angle", want.shoulder_angle, out_data.shoulder_angle);
          check_angle("elbow_angle", want.elbow_angle, out_data.elbow_angle);
          check_angle("wrist_tilt_angle", want.wrist_tilt_angle, out_data.wrist_tilt_angle);
          check_angle("wrist_turn_angle", want.wrist_turn_angle, out_data.wrist_turn_angle);
          check_angle("gripper_angle", want.gripper_angle, out_data.gripper_angle);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_X_MIN:    x_lo    = cfg_data;
          REG_X_MAX:    x_hi    = cfg_data;
          REG_Y_MIN:    y_lo    = cfg_data;
          REG_Y_MAX:    y_hi    = cfg_data;
          REG_ARM_MIN:  arm_lo  = cfg_data[7:0];
          REG_ARM_MAX:  arm_hi  = cfg_data[7:0];
          REG_GRIP_MIN: grip_lo = cfg_data[7:0];
          REG_GRIP_MAX: grip_hi = cfg_data[7:0];
        endcase
      end
      if (in_valid && in_ready) pending_angles.push_back(predict_angles(in_data));
    end
    fail_count <= n_fail;
    pending    <= pending_angles.size();
    checked    <= n_checked;
  end

endmodule
`default_nettype wire

>>> test/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smsc_pkg::*;

  localparam int DEPTH = 5;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b1;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0] cfg_index = REG_X_MIN;
  logic [9:0] cfg_data = '0;

  int fail_count, pending, checked;

  int gap_pct = 0;
  int stall_pct = 5;
  bit calm = 1'b0;
  int rx_hold = 0;
  int n_sent = 0;
  int n_phases = 0;

  // scale currently loaded, used to aim samples at the edges
  sample_t x_lo = '0, x_hi = 10'd1023, y_lo = '0, y_hi = 10'd1023;
  sample_t last_x [3] = '{default: 10'd512};
  sample_t last_y [3] = '{default: 10'd512};

  always #10 clk = ~clk;

  six_channel_median_scale #(.WINDOW_DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  smsc_checker #(.WINDOW_DEPTH(DEPTH)) u_chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  // receiver: random stall bursts of random length, none while calm
  always @(posedge clk) begin
    if (rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_hold == 1) begin
      rx_hold   <= 0;
      out_ready <= 1'b1;
    end else if (!calm && $urandom_range(99) < stall_pct) begin
      rx_hold   <= $urandom_range(14, 1);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic sample_t pick_sample(sample_t prev, sample_t lo, sample_t hi);
    int v;
    case ($urandom_range(9))
      0, 1, 2: v = int'($urandom_range(1023));
      3:       v = $urandom_range(1) ? 1023 : 0;
      4:       v = $urandom_range(1) ? 1022 : 1;
      5, 6:    v = ($urandom_range(1) ? int'(lo) : int'(hi)) + int'($urandom_range(8)) - 4;
      default: v = int'(prev) + int'($urandom_range(40)) - 20;  // slow drift
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return sample_t'(v);
  endfunction

  function automatic in_item_t make_report();
    in_item_t r;
    int       e;
    r.emitter = ($urandom_range(7) == 0) ? EMIT_NONE : 2'($urandom_range(2));
    e = (r.emitter == EMIT_NONE) ? int'($urandom_range(2)) : int'(r.emitter);
    r.x_sample = pick_sample(last_x[e], x_lo, x_hi);
    r.y_sample = pick_sample(last_y[e], y_lo, y_hi);
    if (r.emitter != EMIT_NONE) begin
      last_x[e] = r.x_sample;
      last_y[e] = r.y_sample;
    end
    return r;
  endfunction

  // valid stays high into the next item unless a gap is taken
  task automatic send_report(in_item_t r);
    if (!calm && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_scales(sample_t xl, sample_t xh, sample_t yl, sample_t yh,
                             angle_t al, angle_t ah, angle_t gl, angle_t gh);
    write_reg(REG_X_MIN, xl);
    write_reg(REG_X_MAX, xh);
    write_reg(REG_Y_MIN, yl);
    write_reg(REG_Y_MAX, yh);
    write_reg(REG_ARM_MIN, 10'(al));
    write_reg(REG_ARM_MAX, 10'(ah));
    write_reg(REG_GRIP_MIN, 10'(gl));
    write_reg(REG_GRIP_MAX, 10'(gh));
    cfg_valid <= 1'b0;
    x_lo = xl;
    x_hi = xh;
    y_lo = yl;
    y_hi = yh;
  endtask

  task automatic run_phase(sample_t xl, sample_t xh, sample_t yl, sample_t yh,
                           angle_t al, angle_t ah, angle_t gl, angle_t gh, int n_items);
    settle();
    case ($urandom_range(2))
      0: stall_pct <= 0;
      1: stall_pct <= 3;
      default: stall_pct <= 15;
    endcase
    gap_pct <= $urandom_range(1) ? 0 : 30;
    load_scales(xl, xh, yl, yh, al, ah, gl, gh);
    repeat (n_items) send_report(make_report());
    n_phases++;
  endtask

  initial begin
    in_item_t directed [19] = '{
      '{2'd0, 10'd0, 10'd1023}, '{2'd0, 10'd0, 10'd1023}, '{2'd0, 10'd0, 10'd1023},
      '{2'd1, 10'd1023, 10'd0}, '{2'd1, 10'd1023, 10'd0}, '{2'd1, 10'd1023, 10'd0},
      '{2'd2, 10'd1023, 10'd1023}, '{2'd2, 10'd1023, 10'd1023},
      '{2'd2, 10'd1023, 10'd1023},
      '{EMIT_NONE, 10'd1023, 10'd1023}, '{EMIT_NONE, 10'd1023, 10'd1023},
      '{2'd0, 10'd512, 10'd511}, '{EMIT_NONE, 10'd0, 10'd0},
      '{2'd2, 10'd0, 10'd0}, '{2'd2, 10'd0, 10'd0}, '{2'd2, 10'd0, 10'd0},
      '{2'd1, 10'd341, 10'd682}, '{2'd1, 10'd341, 10'd682}, '{2'd1, 10'd341, 10'd682}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_report(directed[i]);

    run_phase(10'd0, 10'd1023, 10'd0, 10'd1023, 8'd0, 8'd180, 8'd0, 8'd180, 193);
    // narrow scale: samples outside it saturate
    run_phase(10'd100, 10'd900, 10'd200, 10'd800, 8'd10, 8'd170, 8'd30, 8'd90, 193);
    // reversed scales and ranges
    run_phase(10'd1023, 10'd0, 10'd900, 10'd50, 8'd180, 8'd0, 8'd90, 8'd20, 193);
    // equal scale ends give the range's first angle
    run_phase(10'd500, 10'd500, 10'd0, 10'd0, 8'd45, 8'd135, 8'd180, 8'd180, 193);
    run_phase(10'd0, 10'd1, 10'd1022, 10'd1023, 8'd0, 8'd0, 8'd0, 8'd180, 193);
    run_phase(10'd1023, 10'd1023, 10'd0, 10'd1023, 8'd180, 8'd180, 8'd180, 8'd0, 193);
    repeat (3)
      run_phase(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                10'($urandom_range(1023)), 10'($urandom_range(1023)),
                8'($urandom_range(180)), 8'($urandom_range(180)),
                8'($urandom_range(180)), 8'($urandom_range(180)), 193);
    calm <= 1'b1;
    run_phase(10'd0, 10'd1023, 10'd0, 10'd1023, 8'd0, 8'd180, 8'd0, 8'd180, 193);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (100) @(posedge clk);

    $display("Sent %0d joystick reports over %0d scale settings, %0d angle sets compared.",
             n_sent, n_phases + 1, checked);
    $display("Settings spanned reset, narrow, reversed, equal-end, pinned and random scales.");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #18_000_000;
    $display("Timed out with %0d angle sets outstanding.", pending);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
